### hw/rtl/cross_window_dilate_erode_edge_unit_macros.svh
// ----------------------------------------------------------------------------
// cross window dilate/erode/edge unit - assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef CROSS_WINDOW_DILATE_ERODE_EDGE_UNIT_MACROS_SVH
`define CROSS_WINDOW_DILATE_ERODE_EDGE_UNIT_MACROS_SVH

// same-cycle implication
`define CWDE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cwde check failed");

// next-cycle implication
`define CWDE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cwde check failed");

`endif

### hw/rtl/cwde_pkg.sv
// ----------------------------------------------------------------------------
// cwde_pkg
// types and constants of the cross window dilate/erode/edge unit
// ----------------------------------------------------------------------------
package cwde_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIX_W         = 8;
    localparam int IMG_W_W       = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 11'd1024;
    localparam logic [PIX_W-1:0]   MATCH_RST       = 8'd0;
    localparam logic [PIX_W-1:0]   MARK_RST        = 8'd255;
    localparam logic               KEEP_RST        = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 3'd0,
        CFG_MATCH_VALUE = 3'd1,
        CFG_MARK_VALUE  = 3'd2,
        CFG_KEEP_SOURCE = 3'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ROWS_NONE = 2'd0,
        ROWS_ONE  = 2'd1,
        ROWS_TWO  = 2'd2
    } rows_t;

    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_end;
        logic             frame_end;
    } out_item_t;

endpackage

### hw/rtl/cwde_ram.sv
// ----------------------------------------------------------------------------
// cwde_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cwde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/cwde_cell.sv
// ----------------------------------------------------------------------------
// cwde_cell
// one pixel cell of the horizontal window chain
// ----------------------------------------------------------------------------
module cwde_cell
    import cwde_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic             load,
    input  logic [PIX_W-1:0] shift_in,
    input  logic [PIX_W-1:0] load_in,
    output logic [PIX_W-1:0] q
);

    logic [PIX_W-1:0] q_reg;
    logic [PIX_W-1:0] q_next;

    always_comb begin
        q_next = q_reg;
        if (en) begin
            q_next = load ? load_in : shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### hw/rtl/cross_window_dilate_erode_edge_unit.sv
// ----------------------------------------------------------------------------
// cross_window_dilate_erode_edge_unit
// 4-neighbor boundary marking on a raster pixel stream, one row late
// ----------------------------------------------------------------------------
//  channel  ports                            moves
//  s_       s_valid s_ready s_data           pixel or flush item
//  m_       m_valid m_ready m_data           result pixel with row/frame ends
//  cfg      cfg_valid cfg_ready cfg_index    register write
//           cfg_data
//
//  one item per clock unless the output stalls; a result sits in the output
//  register the cycle after its item is accepted, and the next item is taken
//  in the same cycle that result leaves. line buffers are two dual-port rams
//  (one write, one read each); reads run one column ahead. synchronous reset
//  clears counters and m_valid, resets config; ram contents are not cleared.
// ----------------------------------------------------------------------------
module cross_window_dilate_erode_edge_unit
    import cwde_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = COL_W + 1;

    logic [IMG_W_W-1:0] image_width_reg, image_width_next;
    logic [PIX_W-1:0]   match_reg, match_next;
    logic [PIX_W-1:0]   mark_reg, mark_next;
    logic               keep_reg, keep_next;

    logic [COL_W-1:0]   col_reg, col_next;
    rows_t              rows_reg, rows_next;
    logic [PIX_W-1:0]   row0_reg, row0_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;
    logic               byp_r_reg, byp_r_next;
    logic [PIX_W-1:0]   byp_r_data_reg, byp_r_data_next;
    logic               byp_a_reg, byp_a_next;
    logic [PIX_W-1:0]   byp_a_data_reg, byp_a_data_next;

    logic               accept, flush, emit, last, wrap, boundary;
    logic [31:0]        w_wide;
    logic [CNT_W-1:0]   w_act, x_plus;
    logic [PIX_W-1:0]   c, l, r, a, b, pix;
    logic [PIX_W-1:0]   centre_q, left_q, recent_q, older_q, r_data, a_data;
    logic               recent_we, older_we;
    logic [COL_W-1:0]   recent_raddr, older_raddr;
    out_item_t          res;

    // config port
    assign cfg_ready = 1'b1;

    always_comb begin
        image_width_next = image_width_reg;
        match_next       = match_reg;
        mark_next        = mark_reg;
        keep_next        = keep_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                CFG_IMAGE_WIDTH: image_width_next = cfg_data[IMG_W_W-1:0];
                CFG_MATCH_VALUE: match_next       = cfg_data[PIX_W-1:0];
                CFG_MARK_VALUE:  mark_next        = cfg_data[PIX_W-1:0];
                CFG_KEEP_SOURCE: keep_next        = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // window and decision
    assign accept = s_valid && s_ready;
    assign flush  = (s_data.op == OP_FLUSH);
    assign pix    = s_data.pixel_in;
    assign emit   = (rows_reg != ROWS_NONE);
    assign w_wide = 32'(image_width_reg);

    always_comb begin
        if (image_width_reg == '0) begin
            w_act = CNT_W'(1);
        end else if (w_wide > 32'(MAX_WIDTH)) begin
            w_act = CNT_W'(MAX_WIDTH);
        end else begin
            w_act = CNT_W'(w_wide);
        end
    end

    assign x_plus = {1'b0, col_reg} + CNT_W'(1);
    assign last   = (x_plus >= w_act);
    assign wrap   = last || (!emit && flush);

    assign r_data = byp_r_reg ? byp_r_data_reg : recent_q;
    assign a_data = byp_a_reg ? byp_a_data_reg : older_q;

    assign c = centre_q;
    assign l = (col_reg != '0) ? left_q : c;
    assign r = last ? c : r_data;
    assign a = (rows_reg == ROWS_TWO) ? a_data : c;
    assign b = flush ? c : pix;

    assign boundary = (c == match_reg) && ((l != c) || (r != c) || (a != c) || (b != c));

    always_comb begin
        res.pixel_out = boundary ? mark_reg : (keep_reg ? c : '0);
        res.row_end   = last;
        res.frame_end = flush && last;
    end

    // counters
    assign col_next  = accept ? (wrap ? '0 : x_plus[COL_W-1:0]) : col_reg;
    assign row0_next = (accept && (col_reg == '0) && !flush) ? pix : row0_reg;

    always_comb begin
        rows_next = rows_reg;
        if (accept && last) begin
            if (emit) begin
                if (flush) begin
                    rows_next = ROWS_NONE;
                end else if (rows_reg == ROWS_ONE) begin
                    rows_next = ROWS_TWO;
                end
            end else if (!flush) begin
                rows_next = ROWS_ONE;
            end
        end
    end

    // line buffers, read one column ahead with same-cycle bypass
    assign recent_we    = accept && !flush;
    assign older_we     = accept && emit && !flush;
    assign recent_raddr = col_next + COL_W'(1);
    assign older_raddr  = col_next;

    assign byp_r_next      = recent_we && (col_reg == recent_raddr);
    assign byp_r_data_next = pix;
    assign byp_a_next      = older_we && (col_reg == older_raddr);
    assign byp_a_data_next = c;

    cwde_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_recent_ram (
        .aclk  (aclk),
        .we    (recent_we),
        .waddr (col_reg),
        .wdata (pix),
        .raddr (recent_raddr),
        .rdata (recent_q)
    );

    cwde_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .aclk  (aclk),
        .we    (older_we),
        .waddr (col_reg),
        .wdata (c),
        .raddr (older_raddr),
        .rdata (older_q)
    );

    // window chain: next column -> centre -> left
    cwde_cell u_centre_cell (
        .aclk     (aclk),
        .en       (accept),
        .load     (wrap),
        .shift_in (r_data),
        .load_in  (row0_next),
        .q        (centre_q)
    );

    cwde_cell u_left_cell (
        .aclk     (aclk),
        .en       (accept && emit),
        .load     (1'b0),
        .shift_in (centre_q),
        .load_in  ('0),
        .q        (left_q)
    );

    // output register
    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept && emit) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg <= IMAGE_WIDTH_RST;
            match_reg       <= MATCH_RST;
            mark_reg        <= MARK_RST;
            keep_reg        <= KEEP_RST;
            col_reg         <= '0;
            rows_reg        <= ROWS_NONE;
            m_valid_reg     <= 1'b0;
            byp_r_reg       <= 1'b0;
            byp_a_reg       <= 1'b0;
        end else begin
            image_width_reg <= image_width_next;
            match_reg       <= match_next;
            mark_reg        <= mark_next;
            keep_reg        <= keep_next;
            col_reg         <= col_next;
            rows_reg        <= rows_next;
            m_valid_reg     <= m_valid_next;
            byp_r_reg       <= byp_r_next;
            byp_a_reg       <= byp_a_next;
        end
    end

    always_ff @(posedge aclk) begin
        row0_reg       <= row0_next;
        m_data_reg     <= m_data_next;
        byp_r_data_reg <= byp_r_data_next;
        byp_a_data_reg <= byp_a_data_next;
    end

endmodule

### hw/rtl/cwde_checker.sv
// ----------------------------------------------------------------------------
// cwde_checker
// port-level checks of the cross window dilate/erode/edge unit
// ----------------------------------------------------------------------------
`include "cross_window_dilate_erode_edge_unit_macros.svh"

module cwde_checker
    import cwde_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic out_stall;
    logic frame_out;
    logic pixel_take;

    assign out_stall  = m_valid && !m_ready;
    assign frame_out  = m_valid && m_data.frame_end;
    assign pixel_take = s_valid && s_ready && (s_data.op == OP_PIXEL);

    // stalled item holds
    `CWDE_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_valid && $stable(m_data))

    // an empty output register never blocks the input
    `CWDE_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // frame end only on the last pixel of a row
    `CWDE_ASSERT_NOW(a_frame_on_row_end, aclk, aresetn, frame_out, m_data.row_end)

    // pixel items never close a frame
    `CWDE_ASSERT_NEXT(a_pixel_no_frame_end, aclk, aresetn, pixel_take, !frame_out)

endmodule

bind cross_window_dilate_erode_edge_unit cwde_checker u_cwde_checker (.*);

### tb/tb_cross_window_dilate_erode_edge_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cross_window_dilate_erode_edge_unit
// Streams frames of pixels and flush items through the unit under random
// source gaps and sink stalls. A behavioral copy of the 4-neighbor marking
// logic runs on every accepted item and queues the result pixel it implies.
// Each result leaving the unit is checked field by field against that queue.
// Register settings change between frames, and the image width is also
// lowered in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_cross_window_dilate_erode_edge_unit;
    import cwde_pkg::*;

    localparam int                   QUIET_LIMIT   = 2000;
    localparam int                   HOLD_CYCLES   = 300;
    localparam int                   ITEM_TARGET   = 550;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // register copy
    logic [IMG_W_W-1:0] cfg_width = IMAGE_WIDTH_RST;
    logic [PIX_W-1:0]   cfg_match = MATCH_RST;
    logic [PIX_W-1:0]   cfg_mark  = MARK_RST;
    logic               cfg_keep  = KEEP_RST;

    // window state copy
    logic [PIX_W-1:0] cur_line   [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] prior_line [MAX_WIDTH_DEF];
    int               col_pos     = 0;
    rows_t            rows_done   = ROWS_NONE;
    logic [PIX_W-1:0] prev_centre = '0;

    in_item_t  pending_items   [$];
    out_item_t expected_pixels [$];

    // position of the generated stream
    int plan_col   = 0;
    int plan_rows  = 0;
    int items_sent = 0;

    bit        src_idle_en  = 1'b1;
    bit        sink_idle_en = 1'b1;
    int        src_gap      = 0;
    int        sink_gap     = 0;
    int        hold_asked   = 0;
    int        hold_seen    = 0;
    int        mismatches   = 0;
    int        quiet        = 0;
    bit        has_res;
    out_item_t res_item;
    out_item_t want;

    cross_window_dilate_erode_edge_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int active_cols(logic [IMG_W_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return int'(w);
    endfunction

    function automatic int gap_len();
        int roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int roll = $urandom_range(0, 99);
        if (roll < 45) return cfg_match;
        if (roll < 65) return ~cfg_match;
        return PIX_W'($urandom);
    endfunction

    task automatic mark_boundary_pixel(input in_item_t it, output bit produced,
                                       output out_item_t res);
        int               w;
        int               x;
        bit               last;
        bit               flush;
        logic [PIX_W-1:0] c, l, r, a, b;
        w        = active_cols(cfg_width);
        flush    = (it.op == OP_FLUSH);
        x        = (col_pos >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_pos;
        last     = (x + 1 >= w);
        produced = 1'b0;
        res      = '0;
        if (rows_done == ROWS_NONE) begin
            if (!flush) cur_line[x] = it.pixel_in;
            if (!flush && last) rows_done = ROWS_ONE;
            col_pos = (flush || last) ? 0 : x + 1;
            return;
        end
        c = cur_line[x];
        l = (x > 0) ? prev_centre : c;
        r = last ? c : cur_line[x + 1];
        a = (rows_done == ROWS_TWO) ? prior_line[x] : c;
        b = flush ? c : it.pixel_in;
        if (c == cfg_match && (l != c || r != c || a != c || b != c)) begin
            res.pixel_out = cfg_mark;
        end else begin
            res.pixel_out = cfg_keep ? c : '0;
        end
        res.row_end   = last;
        res.frame_end = flush && last;
        produced      = 1'b1;
        prev_centre   = c;
        if (!flush) begin
            prior_line[x] = c;
            cur_line[x]   = it.pixel_in;
        end
        if (last) begin
            col_pos = 0;
            if (flush) rows_done = ROWS_NONE;
            else if (rows_done == ROWS_ONE) rows_done = ROWS_TWO;
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic add_pixel(input logic [PIX_W-1:0] value);
        in_item_t it;
        int       x;
        it.op       = OP_PIXEL;
        it.pixel_in = value;
        pending_items.push_back(it);
        items_sent++;
        x = (plan_col >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : plan_col;
        if (x + 1 >= active_cols(cfg_width)) begin
            plan_col = 0;
            plan_rows++;
        end else begin
            plan_col = x + 1;
        end
    endtask

    task automatic add_flush();
        in_item_t it;
        int       x;
        it.op       = OP_FLUSH;
        it.pixel_in = PIX_W'($urandom);
        pending_items.push_back(it);
        x = (plan_col >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : plan_col;
        if (plan_rows == 0) begin
            plan_col = 0;
        end else begin
            items_sent++;
            if (x + 1 >= active_cols(cfg_width)) begin
                plan_col  = 0;
                plan_rows = 0;
            end else begin
                plan_col = x + 1;
            end
        end
    endtask

    task automatic finish_frame();
        while (plan_rows != 0 || plan_col != 0) add_flush();
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH: cfg_width = IMG_W_W'(value);
            CFG_MATCH_VALUE: cfg_match = PIX_W'(value);
            CFG_MARK_VALUE:  cfg_mark  = PIX_W'(value);
            CFG_KEEP_SOURCE: cfg_keep  = value[0];
            default: ;
        endcase
    endtask

    task automatic run_frame(input int rows_a, input int part_a, input bit do_lower,
                             input int low_w, input int rows_b);
        int cols;
        @(negedge aclk);
        if ($urandom_range(0, 6) == 0) add_flush();
        cols = active_cols(cfg_width);
        repeat (rows_a * cols + part_a) add_pixel(pick_pixel());
        if (do_lower) begin
            wait_idle();
            write_reg(CFG_IMAGE_WIDTH, low_w);
            @(negedge aclk);
            while (plan_col != 0) add_pixel(pick_pixel());
        end
        cols = active_cols(cfg_width);
        repeat (rows_b * cols + $urandom_range(0, cols - 1)) add_pixel(pick_pixel());
        finish_frame();
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                mark_boundary_pixel(s_data, has_res, res_item);
                if (has_res) expected_pixels.push_back(res_item);
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    src_gap = src_idle_en ? gap_len() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result %0d %0b %0b", $realtime,
                                 m_data.pixel_out, m_data.row_end, m_data.frame_end);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_data.pixel_out !== want.pixel_out || m_data.row_end !== want.row_end ||
                        m_data.frame_end !== want.frame_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %0d %0b %0b, got %0d %0b %0b",
                                     $realtime, want.pixel_out, want.row_end,
                                     want.frame_end, m_data.pixel_out, m_data.row_end,
                                     m_data.frame_end);
                    end
                end
            end
            if (hold_asked != hold_seen && m_valid) begin
                hold_seen = hold_asked;
                sink_gap  = HOLD_CYCLES;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                sink_gap = sink_idle_en ? gap_len() : 0;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("FAIL cross_window_dilate_erode_edge_unit");
                $finish;
            end
        end
    end

    initial begin
        int  roll;
        bit  first;
        int  cols;
        int  rows_a;
        int  part_a;
        bit  do_lower;
        int  low_w;
        foreach (cur_line[i]) begin
            cur_line[i]   = '0;
            prior_line[i] = '0;
        end
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // dilate on a 3-wide frame, flush before anything and flush mid-row
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_MATCH_VALUE, 0);
        write_reg(CFG_MARK_VALUE, 255);
        write_reg(CFG_KEEP_SOURCE, 1);
        write_reg(CFG_SPARE_IDX, 2047);
        @(negedge aclk);
        add_flush();
        add_pixel(8'd0);   add_pixel(8'd255); add_pixel(8'd0);
        add_pixel(8'd255); add_pixel(8'd0);   add_pixel(8'd255);
        add_pixel(8'd0);   add_pixel(8'd0);   add_pixel(8'd255);
        add_pixel(8'd0);
        finish_frame();
        wait_idle();

        // erode with zero fill on a width that acts as one column
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_MATCH_VALUE, 255);
        write_reg(CFG_MARK_VALUE, 0);
        write_reg(CFG_KEEP_SOURCE, 0);
        @(negedge aclk);
        add_pixel(8'd255); add_pixel(8'd0); add_pixel(8'd255); add_pixel(8'd255);
        finish_frame();
        wait_idle();

        // partial first row dropped by a flush
        write_reg(CFG_IMAGE_WIDTH, 2);
        @(negedge aclk);
        add_pixel(8'hA5);
        finish_frame();

        first = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (first)         write_reg(CFG_IMAGE_WIDTH, 2047);
            else if (roll < 8)  write_reg(CFG_IMAGE_WIDTH, 0);
            else if (roll < 16) write_reg(CFG_IMAGE_WIDTH, 1);
            else if (roll < 85) write_reg(CFG_IMAGE_WIDTH, $urandom_range(2, 8));
            else                write_reg(CFG_IMAGE_WIDTH, $urandom_range(9, 40));
            if ($urandom_range(0, 9) < 6) begin
                roll = $urandom_range(0, 99);
                write_reg(CFG_MATCH_VALUE, roll < 30 ? 0 : roll < 60 ? 255 : $urandom_range(0, 255));
            end
            if ($urandom_range(0, 9) < 6) begin
                roll = $urandom_range(0, 99);
                write_reg(CFG_MARK_VALUE, roll < 30 ? 255 : roll < 60 ? 0 : $urandom_range(0, 255));
            end
            if ($urandom_range(0, 9) < 6) write_reg(CFG_KEEP_SOURCE, $urandom_range(0, 1));
            cols = active_cols(cfg_width);
            if (first) begin
                // widest setting, then the width drops in the middle of the first row
                hold_asked++;
                run_frame(0, 200, 1'b1, 3, 2);
                first = 1'b0;
            end else begin
                rows_a   = (cols >= 20) ? $urandom_range(0, 2) : $urandom_range(0, 4);
                part_a   = $urandom_range(0, cols - 1);
                do_lower = (cols >= 2) && ($urandom_range(0, 4) == 0);
                low_w    = (cols >= 2) ? $urandom_range(0, cols - 1) : 1;
                run_frame(rows_a, part_a, do_lower, low_w, $urandom_range(0, 2));
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("PASS cross_window_dilate_erode_edge_unit");
        end else begin
            $display("FAIL cross_window_dilate_erode_edge_unit");
        end
        $finish;
    end

endmodule
